FILE: hdl/p2r_pkg.sv
// Types, constants and tables shared by the polar to rectangular converter.
// No dependencies.
package p2r_pkg;

    localparam int AMP_WIDTH   = 16;
    localparam int PHASE_WIDTH = 17;
    localparam int ANG_W       = 32;
    localparam int XY_W        = AMP_WIDTH + 18;
    localparam int FRAC        = 16;
    localparam int TABLE_LEN   = 24;

    // Gain compensation, Q30, applied as amp*K >> 14 to land in Q16.
    localparam int GAIN_W     = 31;
    localparam int PROD_W     = AMP_WIDTH + GAIN_W;
    localparam int GAIN_SHIFT = 30 - FRAC;
    localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 31'sd652032874;

    // Phase (deg*256) to binary angle: 92160 = 45 * 2^11.
    localparam logic [PHASE_WIDTH-1:0] PH_TURN = 17'd92160;
    localparam int PH_DIV      = 45;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 23;
    localparam logic [RECIP_W-1:0] RECIP = 18'd186414;
    localparam int PH_PROD_W   = PHASE_WIDTH + RECIP_W;
    localparam int QUOT_W      = 11;
    localparam int REM_W       = 6;
    localparam int FINE_W      = 21;
    localparam int FINE_BIAS   = 22;

    localparam logic signed [ANG_W-1:0] QUARTER_TURN     = 32'sh4000_0000;
    localparam logic signed [ANG_W-1:0] NEG_QUARTER_TURN = 32'shC000_0000;

    localparam logic signed [XY_W-1:0] ROUND_HALF = XY_W'(64'd1 << (FRAC - 1));
    localparam logic signed [XY_W-1:0] SAT_HI = XY_W'((64'd1 << (AMP_WIDTH - 1)) - 64'd1);
    localparam logic signed [XY_W-1:0] SAT_LO = -SAT_HI - XY_W'(1);

    localparam logic [ANG_W-1:0] ATAN_TBL [TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef logic [FINE_W-1:0] t_fine_tbl [2**REM_W];

    // Low angle bits for each remainder of phase / 45; unused codes read zero.
    function automatic t_fine_tbl fine_table();
        t_fine_tbl tbl;
        for (int b = 0; b < 2**REM_W; b++) begin
            if (b < PH_DIV) begin
                tbl[b] = FINE_W'(((longint'(b) <<< FINE_W) + FINE_BIAS) / PH_DIV);
            end else begin
                tbl[b] = '0;
            end
        end
        return tbl;
    endfunction

    typedef struct packed {
        logic signed [AMP_WIDTH-1:0] amplitude;
        logic [PHASE_WIDTH-1:0]      phase;
        logic                        line_end_in;
    } t_in_item;

    typedef struct packed {
        logic signed [AMP_WIDTH-1:0] real_part;
        logic signed [AMP_WIDTH-1:0] imag_part;
        logic                        phase_bad;
        logic                        line_end_out;
    } t_out_item;

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
        logic                    bad;
        logic                    line_end;
    } t_rot;

endpackage

FILE: hdl/polar_to_rectangular_unit.sv
// Polar to rectangular converter, top level: front end, CORDIC chain, output.
// Depends on p2r_pkg, p2r_front, p2r_stage, p2r_back.
//
// Input channel i_in_valid/o_in_ready carries amplitude, phase (deg*256) and
// a row-end marker; output channel o_out_valid/i_out_ready returns the
// saturated real and imaginary parts, a bad-phase flag and the marker.
// One transfer per clock is sustained in both directions while i_out_ready is high.
// The pipeline holds three front stages (phase scaling, remainder, angle
// fold), one register per micro-rotation and one output register. Each
// stage advances when it is empty or its successor advances,
// so bubbles close up while the output is stalled and the input keeps
// accepting until every stage holds an item. A stall loses nothing.
// Phases of 360 degrees or more give zero results with phase_bad set.
// Reset (i_rst_n low, synchronous) empties the pipeline; no item is in flight
// afterward and results appear only for transfers accepted after it.
module polar_to_rectangular_unit
    import p2r_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int N_ROT = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

    t_rot rot   [N_ROT+1];
    logic vld   [N_ROT+1];
    logic rdy   [N_ROT+1];

    p2r_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_ready (o_in_ready),
        .i_take  (rdy[0]),
        .o_valid (vld[0]),
        .o_rot   (rot[0])
    );

    for (genvar g = 0; g < N_ROT; g++) begin : g_rot
        p2r_stage #(
            .IDX (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[g]),
            .i_rot   (rot[g]),
            .o_ready (rdy[g]),
            .i_take  (rdy[g+1]),
            .o_valid (vld[g+1]),
            .o_rot   (rot[g+1])
        );
    end

    p2r_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (vld[N_ROT]),
        .i_rot       (rot[N_ROT]),
        .o_ready     (rdy[N_ROT]),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // With the output register empty every stage can advance.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

endmodule

FILE: hdl/p2r_front.sv
// Front end: phase to binary angle, quadrant fold and gain-scaled start vector.
// Three register stages. Depends on p2r_pkg.
module p2r_front
    import p2r_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_ready,
    input  logic     i_take,
    output logic     o_valid,
    output t_rot     o_rot
);

    localparam t_fine_tbl FINE_TBL = fine_table();

    logic en1, en2, en3;
    logic r1_valid, r2_valid, r3_valid;

    logic [PHASE_WIDTH-1:0]   r1_ph;
    logic [QUOT_W-1:0]        r1_quot;
    logic signed [PROD_W-1:0] r1_prod;
    logic                     r1_bad, r1_le;

    logic [REM_W-1:0]       r2_rem;
    logic [QUOT_W-1:0]      r2_quot;
    logic signed [XY_W-1:0] r2_x0;
    logic                   r2_bad, r2_le;

    t_rot r3_rot;

    logic [PH_PROD_W-1:0]     n_ph_prod;
    logic signed [PROD_W-1:0] n_prod;
    logic [PHASE_WIDTH-1:0]   n_rem_full;
    logic signed [PROD_W-1:0] n_scaled;
    logic signed [ANG_W-1:0]  n_ang;
    logic                     n_flip;
    t_rot                     n_rot;

    assign en3     = !r3_valid || i_take;
    assign en2     = !r2_valid || en3;
    assign en1     = !r1_valid || en2;
    assign o_ready = en1;
    assign o_valid = r3_valid;
    assign o_rot   = r3_rot;

    always_comb begin
        n_ph_prod = PH_PROD_W'(i_item.phase) * PH_PROD_W'(RECIP);
        n_prod    = PROD_W'(i_item.amplitude) * PROD_W'(GAIN_Q30);
    end

    always_comb begin
        n_rem_full = r1_ph - (PHASE_WIDTH'(r1_quot) * PHASE_WIDTH'(PH_DIV));
        n_scaled   = r1_prod >>> GAIN_SHIFT;
    end

    always_comb begin
        n_ang  = {r2_quot, FINE_TBL[r2_rem]};
        n_flip = (n_ang > QUARTER_TURN) || (n_ang < NEG_QUARTER_TURN);
        n_rot.x        = n_flip ? -r2_x0 : r2_x0;
        n_rot.y        = '0;
        n_rot.z        = n_flip ? {~n_ang[ANG_W-1], n_ang[ANG_W-2:0]} : n_ang;
        n_rot.bad      = r2_bad;
        n_rot.line_end = r2_le;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (en1) r1_valid <= i_valid;
            if (en2) r2_valid <= r1_valid;
            if (en3) r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_ph   <= i_item.phase;
            r1_quot <= n_ph_prod[RECIP_SHIFT +: QUOT_W];
            r1_prod <= n_prod;
            r1_bad  <= (i_item.phase >= PH_TURN);
            r1_le   <= i_item.line_end_in;
        end
        if (en2) begin
            r2_rem  <= n_rem_full[REM_W-1:0];
            r2_quot <= r1_quot;
            r2_x0   <= XY_W'(n_scaled);
            r2_bad  <= r1_bad;
            r2_le   <= r1_le;
        end
        if (en3) begin
            r3_rot <= n_rot;
        end
    end

    // Folded angle must lie within a quarter turn either side of zero.
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_valid && !r3_rot.bad) |->
            (r3_rot.z <= QUARTER_TURN) && (r3_rot.z >= NEG_QUARTER_TURN))
        else $error("folded angle out of range");

endmodule

FILE: hdl/p2r_stage.sv
// One registered CORDIC micro-rotation with shift and angle set by IDX.
// Depends on p2r_pkg.
module p2r_stage
    import p2r_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_rot i_rot,
    output logic o_ready,
    input  logic i_take,
    output logic o_valid,
    output t_rot o_rot
);

    logic en;
    logic r_valid;
    t_rot r_rot;
    t_rot n_rot;
    logic signed [XY_W-1:0]  xs, ys;
    logic signed [ANG_W-1:0] step;

    assign en      = !r_valid || i_take;
    assign o_ready = en;
    assign o_valid = r_valid;
    assign o_rot   = r_rot;

    always_comb begin
        xs   = $signed(i_rot.x) >>> IDX;
        ys   = $signed(i_rot.y) >>> IDX;
        step = $signed(ATAN_TBL[IDX]);
        n_rot = i_rot;
        if (!i_rot.z[ANG_W-1]) begin
            n_rot.x = i_rot.x - ys;
            n_rot.y = i_rot.y + xs;
            n_rot.z = i_rot.z - step;
        end else begin
            n_rot.x = i_rot.x + ys;
            n_rot.y = i_rot.y - xs;
            n_rot.z = i_rot.z + step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rot <= n_rot;
        end
    end

    // A held item keeps its data while the next stage is full.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_take) |=> (r_valid && $stable(r_rot)))
        else $error("stage lost data during stall");

endmodule

FILE: hdl/p2r_back.sv
// Output stage: round Q16 to integer, saturate, zero on bad phase.
// Holds the output register. Depends on p2r_pkg.
module p2r_back
    import p2r_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_rot      i_rot,
    output logic      o_ready,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    logic      en;
    logic      r_valid;
    t_out_item r_item;
    t_out_item n_item;
    logic signed [XY_W-1:0] rx, ry, qx, qy;

    function automatic logic signed [AMP_WIDTH-1:0] sat(input logic signed [XY_W-1:0] v);
        logic signed [AMP_WIDTH-1:0] r;
        if (v > SAT_HI) begin
            r = AMP_WIDTH'(SAT_HI);
        end else if (v < SAT_LO) begin
            r = AMP_WIDTH'(SAT_LO);
        end else begin
            r = v[AMP_WIDTH-1:0];
        end
        return r;
    endfunction

    assign en          = !r_valid || i_out_ready;
    assign o_ready     = en;
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    always_comb begin
        rx = i_rot.x + ROUND_HALF;
        ry = i_rot.y + ROUND_HALF;
        qx = rx >>> FRAC;
        qy = ry >>> FRAC;
        n_item.real_part    = i_rot.bad ? '0 : sat(qx);
        n_item.imag_part    = i_rot.bad ? '0 : sat(qy);
        n_item.phase_bad    = i_rot.bad;
        n_item.line_end_out = i_rot.line_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_item <= n_item;
        end
    end

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_item.phase_bad) |->
            (r_item.real_part == '0) && (r_item.imag_part == '0))
        else $error("bad phase result not zero");

endmodule

FILE: tb/polar_to_rectangular_unit_tb.sv
// Self-checking testbench for polar_to_rectangular_unit: a queued driver,
// a predicting monitor and four handshake patterns on both channels.
// Depends on p2r_pkg and the polar_to_rectangular_unit RTL.
module polar_to_rectangular_unit_tb
    import p2r_pkg::*;
();

    localparam int ROTATIONS   = 16;
    localparam int LATENCY     = ROTATIONS + 4;
    localparam int RANDOM_EACH = 340;
    localparam int N_PATTERNS  = 4;

    localparam int  PHASE_LIMIT = 92160;
    localparam int  ATAN_LEN    = 24;
    localparam int  Q_FRAC      = 16;
    localparam longint GAIN_Q30_L = 64'sd652032874;
    localparam longint FULL_TURN  = 64'sh1_0000_0000;
    localparam longint HALF_TURN  = 64'sh8000_0000;
    localparam longint QTR_TURN   = 64'sh4000_0000;
    localparam longint AMP_HI     = 64'sd32767;
    localparam longint AMP_LO     = -64'sd32768;

    localparam longint ATAN_STEPS [ATAN_LEN] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    localparam int SEND_IDLE_PCT [N_PATTERNS]  = '{0, 78, 0, 38};
    localparam int READY_STALL_PCT [N_PATTERNS] = '{0, 0, 78, 38};

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    t_in_item  pending_samples[$];
    t_out_item expected_rect[$];

    int  send_idle = 0;
    int  ready_stall = 0;
    bit  in_fire = 1'b0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  n_bad_phase = 0;
    int  n_errors = 0;

    polar_to_rectangular_unit #(
        .CORDIC_STAGES(ROTATIONS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_out_item rect_from_polar(t_in_item s);
        t_out_item r;
        longint amp, x, y, z, nx, ny, re, im;
        longint unsigned ang;
        bit turned;
        int stages;
        r = '0;
        r.line_end_out = s.line_end_in;
        if (s.phase >= PHASE_LIMIT) begin
            r.phase_bad = 1'b1;
            return r;
        end
        amp = longint'(s.amplitude);
        ang = ((longint'(s.phase) << 32) + PHASE_LIMIT / 2) / PHASE_LIMIT;
        z = longint'(ang);
        if (z >= HALF_TURN) z = z - FULL_TURN;
        turned = 1'b0;
        if (z > QTR_TURN) begin
            z = z - HALF_TURN;
            turned = 1'b1;
        end else if (z < -QTR_TURN) begin
            z = z + HALF_TURN;
            turned = 1'b1;
        end
        x = (amp * GAIN_Q30_L) >>> (30 - Q_FRAC);
        if (turned) x = -x;
        y = 0;
        stages = (ROTATIONS > ATAN_LEN) ? ATAN_LEN : ROTATIONS;
        for (int i = 0; i < stages; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - ATAN_STEPS[i];
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + ATAN_STEPS[i];
            end
            x = nx;
            y = ny;
        end
        re = (x + (64'sd1 << (Q_FRAC - 1))) >>> Q_FRAC;
        im = (y + (64'sd1 << (Q_FRAC - 1))) >>> Q_FRAC;
        if (re > AMP_HI) re = AMP_HI;
        if (re < AMP_LO) re = AMP_LO;
        if (im > AMP_HI) im = AMP_HI;
        if (im < AMP_LO) im = AMP_LO;
        r.real_part = re[AMP_WIDTH-1:0];
        r.imag_part = im[AMP_WIDTH-1:0];
        return r;
    endfunction

    function automatic t_in_item random_sample();
        t_in_item s;
        int pick;
        s.amplitude = AMP_WIDTH'($urandom());
        if ($urandom_range(7) == 0) begin
            pick = $urandom_range(3);
            case (pick)
                0: s.amplitude = 16'sh7FFF;
                1: s.amplitude = 16'sh8000;
                2: s.amplitude = 16'sh8001;
                default: s.amplitude = '0;
            endcase
        end
        pick = $urandom_range(19);
        if (pick < 2) begin
            s.phase = PHASE_WIDTH'($urandom_range(131071, PHASE_LIMIT));
        end else if (pick < 4) begin
            // around the quadrant folds and the ends of the range
            case ($urandom_range(3))
                0: s.phase = PHASE_WIDTH'($urandom_range(23043, 23037));
                1: s.phase = PHASE_WIDTH'($urandom_range(69123, 69117));
                2: s.phase = PHASE_WIDTH'($urandom_range(3, 0));
                default: s.phase = PHASE_WIDTH'($urandom_range(PHASE_LIMIT - 1,
                                                               PHASE_LIMIT - 4));
            endcase
        end else begin
            s.phase = PHASE_WIDTH'($urandom_range(PHASE_LIMIT - 1, 0));
        end
        s.line_end_in = ($urandom_range(3) == 0);
        return s;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH result %0d: %s got %0d expected %0d", n_checked, what, got, want);
        n_errors++;
    endtask

    task automatic add_sample(logic signed [15:0] amp, int phase, bit le);
        t_in_item s;
        s.amplitude = amp;
        s.phase = phase[PHASE_WIDTH-1:0];
        s.line_end_in = le;
        pending_samples.push_back(s);
    endtask

    task automatic wait_all_returned();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_samples.size() != 0 || (i_in_valid && !in_fire)
                   || expected_rect.size() != 0);
    endtask

    // driver
    always @(negedge i_clk) begin : drive_input
        logic     nxt_valid;
        t_in_item nxt_item;
        nxt_valid = i_in_valid && !in_fire;
        nxt_item  = i_in_item;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!nxt_valid && pending_samples.size() != 0
                     && $urandom_range(99) >= send_idle) begin
            nxt_item  = pending_samples.pop_front();
            nxt_valid = 1'b1;
        end
        i_in_valid  <= nxt_valid;
        i_in_item   <= nxt_item;
        i_out_ready <= ($urandom_range(99) >= ready_stall);
    end

    // monitor
    always @(posedge i_clk) begin : watch_output
        t_out_item want;
        in_fire = i_rst_n && i_in_valid && o_in_ready;
        if (in_fire) begin
            expected_rect.push_back(rect_from_polar(i_in_item));
            n_sent++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_rect.size() == 0) begin
                report_mismatch("result with no transfer pending", 64'sd1, 64'sd0);
            end else begin
                want = expected_rect.pop_front();
                if (o_out_item.real_part !== want.real_part)
                    report_mismatch("real_part", longint'(o_out_item.real_part),
                                    longint'(want.real_part));
                if (o_out_item.imag_part !== want.imag_part)
                    report_mismatch("imag_part", longint'(o_out_item.imag_part),
                                    longint'(want.imag_part));
                if (o_out_item.phase_bad !== want.phase_bad)
                    report_mismatch("phase_bad", longint'(o_out_item.phase_bad),
                                    longint'(want.phase_bad));
                if (o_out_item.line_end_out !== want.line_end_out)
                    report_mismatch("line_end_out", longint'(o_out_item.line_end_out),
                                    longint'(want.line_end_out));
                if (want.phase_bad) n_bad_phase++;
                n_checked++;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < N_PATTERNS; p++) begin
            send_idle   = SEND_IDLE_PCT[p];
            ready_stall = READY_STALL_PCT[p];
            if (p == 0) begin
                add_sample(16'sh7FFF, 0, 1'b0);
                add_sample(16'sh7FFF, 23040, 1'b1);
                add_sample(16'sh7FFF, 46080, 1'b0);
                add_sample(16'sh7FFF, 69120, 1'b0);
                add_sample(16'sh8000, 0, 1'b1);
                add_sample(16'sh8000, 23040, 1'b0);
                add_sample(16'sh8000, 46080, 1'b0);
                add_sample(16'sh8000, 69120, 1'b1);
                add_sample(16'sh8000, 11520, 1'b0);
                add_sample(16'sh7FFF, 23041, 1'b0);
                add_sample(16'sh7FFF, 69119, 1'b0);
                add_sample(16'sh7FFF, 57600, 1'b0);
                add_sample(16'sh7FFF, PHASE_LIMIT - 1, 1'b1);
                add_sample(-16'sd1, PHASE_LIMIT - 1, 1'b0);
                add_sample(16'sd1, 1, 1'b0);
                add_sample(16'sd0, 34560, 1'b1);
                add_sample(16'sd12345, PHASE_LIMIT, 1'b0);
                add_sample(16'sh8000, 131071, 1'b1);
                add_sample(16'sh7FFF, 100000, 1'b0);
                add_sample(16'sh5A5A, 65536, 1'b1);
            end
            repeat (RANDOM_EACH) pending_samples.push_back(random_sample());
            // hold off the sender until the pipeline has fully drained
            wait_all_returned();
        end

        repeat (LATENCY + 20) @(posedge i_clk);
        #1;
        while (expected_rect.size() != 0) begin
            void'(expected_rect.pop_front());
            report_mismatch("expected result never arrived", 64'sd0, 64'sd1);
        end
        $display("Checked %0d results for %0d transfers (%0d out-of-range phases),",
                 n_checked, n_sent, n_bad_phase);
        $display("under free-running, sender-idle, receiver-stall and mixed handshakes.");
        if (n_errors == 0) begin
            $display("polar_to_rectangular_unit_tb passed");
        end else begin
            $display("polar_to_rectangular_unit_tb failed");
        end
        $finish;
    end

    initial begin
        #800000;
        $display("Timeout with %0d results outstanding", expected_rect.size());
        $display("polar_to_rectangular_unit_tb failed");
        $finish;
    end

endmodule
